// ===== hdl/cau_pkg.sv =====
// cau_pkg: shared constants, op codes and stage types for the complex arithmetic unit
// no dependencies
package cau_pkg;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PW = 2 * DW + 1;          // exact cross-product sum width
	localparam int NW = PW + FB + 1;         // dividend width after scaling
	localparam int DVW = 2 * DW + 1;         // divisor width (sum of squares)

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          eq;
		logic          dz;
		logic          ovf;
	} res_t;

	function automatic logic [DW:0] sat_in(input logic signed [NW:0] v);
		logic [DW:0] r;
		logic signed [NW:0] mx;
		logic signed [NW:0] mn;
		mx = (NW+1)'(({{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}}));
		mn = -mx - (NW+1)'(1);
		if (v > mx)
			r = {1'b1, 1'b0, {(DW-1){1'b1}}};
		else if (v < mn)
			r = {1'b1, 1'b1, {(DW-1){1'b0}}};
		else
			r = {1'b0, v[DW-1:0]};
		return r;
	endfunction
endpackage

// ===== hdl/cau_div.sv =====
// cau_div: pipelined restoring divider, one quotient bit per stage
// depends on cau_pkg
module cau_div import cau_pkg::*; (
	input  logic           clk,
	input  logic [NW-1:0]  num,
	input  logic [DVW-1:0] den,
	output logic [NW-1:0]  quo
);
	logic [NW-1:0]  q_s   [NW+1];
	logic [NW-1:0]  n_s   [NW+1];
	logic [DVW:0]   r_s   [NW+1];
	logic [DVW-1:0] d_s   [NW+1];

	assign q_s[0] = '0;
	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DVW+1:0] sh;
		logic [DVW+1:0] df;
		assign sh = {r_s[i], n_s[i][NW-1]};
		assign df = sh - {2'b0, d_s[i]};
		always_ff @(posedge clk) begin
			n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
			d_s[i+1] <= d_s[i];
			if (!df[DVW+1]) begin
				r_s[i+1] <= df[DVW:0];
				q_s[i+1] <= {q_s[i][NW-2:0], 1'b1};
			end else begin
				r_s[i+1] <= sh[DVW:0];
				q_s[i+1] <= {q_s[i][NW-2:0], 1'b0};
			end
		end
	end
	assign quo = q_s[NW];
endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit: top level, front end products, divider, rounding and saturation
// depends on cau_pkg, cau_div
//
// channel  | signals                               | handshake
// ---------+---------------------------------------+---------------------------
// command  | operation a_re a_im b_re b_im         | start high, busy low
// result   | result_re result_im is_equal          | done strobe, one cycle
//          | divide_by_zero overflow               |
//
// the done strobe for an item comes after the operand register, the product and combine
// stages, the divider pipeline of one quotient bit per stage and the output register;
// one item enters each cycle
// busy is always low: the pipeline never stalls, the receiver cannot stall
// reset clears the valid bits only; payload registers hold no reset
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           operation,
	input  logic signed [DW-1:0] a_re,
	input  logic signed [DW-1:0] a_im,
	input  logic signed [DW-1:0] b_re,
	input  logic signed [DW-1:0] b_im,
	output logic                 done,
	output logic signed [DW-1:0] result_re,
	output logic signed [DW-1:0] result_im,
	output logic                 is_equal,
	output logic                 divide_by_zero,
	output logic                 overflow
);
	assign busy = 1'b0;

	// stage 1: register operands
	logic v_s1;
	logic [2:0] op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		op_s1 <= operation;
		ar_s1 <= a_re; ai_s1 <= a_im; br_s1 <= b_re; bi_s1 <= b_im;
	end

	// stage 2: four cross products, two squares, the sum or difference and the equality test
	logic v_s2;
	logic [2:0] op_s2;
	logic signed [2*DW-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic [2*DW-1:0] br2_s2, bi2_s2;
	logic signed [DW:0] sre_s2, sim_s2;
	logic eq_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		rr_s2  <= ar_s1 * br_s1;
		ii_s2  <= ai_s1 * bi_s1;
		ri_s2  <= ar_s1 * bi_s1;
		ir_s2  <= ai_s1 * br_s1;
		br2_s2 <= br_s1 * br_s1;
		bi2_s2 <= bi_s1 * bi_s1;
		eq_s2  <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		if (op_s1 == OP_SUB) begin
			sre_s2 <= {ar_s1[DW-1], ar_s1} - {br_s1[DW-1], br_s1};
			sim_s2 <= {ai_s1[DW-1], ai_s1} - {bi_s1[DW-1], bi_s1};
		end else begin
			sre_s2 <= {ar_s1[DW-1], ar_s1} + {br_s1[DW-1], br_s1};
			sim_s2 <= {ai_s1[DW-1], ai_s1} + {bi_s1[DW-1], bi_s1};
		end
	end

	// stage 3: combine products, form divider operands as magnitudes and the non-divide results
	logic signed [PW-1:0] pre, pim, dre, dim;
	assign pre = PW'(rr_s2) - PW'(ii_s2);
	assign pim = PW'(ri_s2) + PW'(ir_s2);
	assign dre = PW'(rr_s2) + PW'(ii_s2);
	assign dim = PW'(ir_s2) - PW'(ri_s2);

	logic v_s3;
	logic [2:0] op_s3;
	res_t fast_s3;
	logic nre_s3, nim_s3;
	logic [NW-1:0] mre_s3, mim_s3;
	logic [DVW-1:0] den_s3;
	logic dz_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		logic signed [NW:0] rre, rim;
		logic [DW:0] s_re, s_im;
		op_s3  <= op_s2;
		den_s3 <= DVW'(br2_s2) + DVW'(bi2_s2);
		dz_s3  <= (br2_s2 == '0) && (bi2_s2 == '0);
		nre_s3 <= dre[PW-1];
		nim_s3 <= dim[PW-1];
		// dividend magnitude scaled by 2^(FB+1)
		mre_s3 <= NW'(dre[PW-1] ? -dre : dre) << (FB + 1);
		mim_s3 <= NW'(dim[PW-1] ? -dim : dim) << (FB + 1);
		// non-divide results
		case (op_s2)
			OP_ADD, OP_SUB: begin
				s_re = sat_in((NW+1)'(sre_s2));
				s_im = sat_in((NW+1)'(sim_s2));
				fast_s3 <= '{re: s_re[DW-1:0], im: s_im[DW-1:0], eq: 1'b0, dz: 1'b0,
					ovf: s_re[DW] | s_im[DW]};
			end
			OP_MUL: begin
				// nearest, ties away from zero: bias one lower for negative sums
				rre = (NW+1)'((pre + (PW'(1) << (FB - 1))
					- $signed({{(PW-1){1'b0}}, pre[PW-1]})) >>> FB);
				rim = (NW+1)'((pim + (PW'(1) << (FB - 1))
					- $signed({{(PW-1){1'b0}}, pim[PW-1]})) >>> FB);
				s_re = sat_in(rre);
				s_im = sat_in(rim);
				fast_s3 <= '{re: s_re[DW-1:0], im: s_im[DW-1:0], eq: 1'b0, dz: 1'b0,
					ovf: s_re[DW] | s_im[DW]};
			end
			OP_CMP: fast_s3 <= '{re: '0, im: '0, eq: eq_s2, dz: 1'b0, ovf: 1'b0};
			default: fast_s3 <= '0;
		endcase
	end

	// divider lanes
	logic [NW-1:0] qre, qim;
	cau_div u_div_re (.clk, .num(mre_s3), .den(den_s3), .quo(qre));
	cau_div u_div_im (.clk, .num(mim_s3), .den(den_s3), .quo(qim));

	// delay line beside the divider for the side band
	logic       v_d    [NW+1];
	logic [2:0] op_d   [NW+1];
	res_t       fast_d [NW+1];
	logic       nre_d  [NW+1];
	logic       nim_d  [NW+1];
	logic       dz_d   [NW+1];
	assign v_d[0] = v_s3; assign op_d[0] = op_s3; assign fast_d[0] = fast_s3;
	assign nre_d[0] = nre_s3; assign nim_d[0] = nim_s3; assign dz_d[0] = dz_s3;
	for (genvar k = 0; k < NW; k++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[k+1] <= 1'b0;
			else v_d[k+1] <= v_d[k];
		end
		always_ff @(posedge clk) begin
			op_d[k+1] <= op_d[k]; fast_d[k+1] <= fast_d[k];
			nre_d[k+1] <= nre_d[k]; nim_d[k+1] <= nim_d[k]; dz_d[k+1] <= dz_d[k];
		end
	end

	// final stage: round quotient, sign, saturate, select
	logic [NW-1:0] hre, him;
	assign hre = (qre + NW'(1)) >> 1;
	assign him = (qim + NW'(1)) >> 1;

	res_t out_q;
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_d[NW];
	end
	always_ff @(posedge clk) begin
		logic [DW:0] s_re, s_im;
		s_re = sat_in(nre_d[NW] ? -(NW+1)'(hre) : (NW+1)'(hre));
		s_im = sat_in(nim_d[NW] ? -(NW+1)'(him) : (NW+1)'(him));
		if (op_d[NW] == OP_DIV) begin
			if (dz_d[NW])
				out_q <= '{re: '0, im: '0, eq: 1'b0, dz: 1'b1, ovf: 1'b0};
			else
				out_q <= '{re: s_re[DW-1:0], im: s_im[DW-1:0], eq: 1'b0, dz: 1'b0,
					ovf: s_re[DW] | s_im[DW]};
		end else begin
			out_q <= fast_d[NW];
		end
	end

	assign done           = done_q;
	assign result_re      = out_q.re;
	assign result_im      = out_q.im;
	assign is_equal       = out_q.eq;
	assign divide_by_zero = out_q.dz;
	assign overflow       = out_q.ovf;

	// a strobe follows every accepted item after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ##(NW + 1) done) else $error("lost item");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(divide_by_zero && overflow)) else $error("dz with overflow");
	a_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_equal) |-> (result_re == '0 && result_im == '0))
		else $error("compare with nonzero parts");
endmodule

// ===== bench/complex_arithmetic_unit_tb.sv =====
// complex_arithmetic_unit_tb: self-checking bench for the complex arithmetic unit
// depends on cau_pkg and the complex_arithmetic_unit rtl; drives commands from a queue,
// predicts each result in wide integer arithmetic and checks it on every done strobe
module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	typedef struct {
		logic [2:0]           op;
		logic signed [DW-1:0] ar;
		logic signed [DW-1:0] ai;
		logic signed [DW-1:0] br;
		logic signed [DW-1:0] bi;
	} cmd_t;

	localparam int STALL_LIMIT = 4000;  // well past the pipeline latency

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] operation = '0;
	logic signed [DW-1:0] a_re = '0;
	logic signed [DW-1:0] a_im = '0;
	logic signed [DW-1:0] b_re = '0;
	logic signed [DW-1:0] b_im = '0;
	logic busy;
	logic done;
	logic signed [DW-1:0] result_re;
	logic signed [DW-1:0] result_im;
	logic is_equal;
	logic divide_by_zero;
	logic overflow;

	cmd_t pending_cmds[$];     // items waiting to be driven
	res_t expected_results[$]; // predictions for items already accepted
	int n_sent = 0;
	int n_errors = 0;
	int quiet_cycles = 0;

	complex_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.done(done), .result_re(result_re), .result_im(result_im),
		.is_equal(is_equal), .divide_by_zero(divide_by_zero), .overflow(overflow)
	);

	always #1 clk = ~clk;

	// clamp a wide signed value into one word, flag when clamped
	function automatic logic [DW-1:0] clamp_word(input logic signed [127:0] v, inout logic ovf);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (DW-1)) - 128'sd1;
		lo = -(128'sd1 <<< (DW-1));
		if (v > hi) begin
			ovf = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// drop the fraction bits of a double-width product, nearest, ties away from zero
	function automatic logic signed [127:0] round_product(input logic signed [127:0] v);
		logic [127:0] mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (128'd1 << (FB-1))) >> FB;
		return (v < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	// scaled quotient n / d rounded to nearest, sign of n (d is positive)
	function automatic logic signed [127:0] round_quotient(input logic signed [127:0] n,
			input logic [127:0] d);
		logic [127:0] mag;
		mag = (n < 0) ? -n : n;
		mag = (((mag << (FB+1)) / d) + 128'd1) >> 1;
		return (n < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic res_t complex_result(input cmd_t c);
		res_t r;
		logic signed [127:0] ar, ai, br, bi, vre, vim;
		logic [127:0] den;
		logic ovf;
		ar = 128'(c.ar);
		ai = 128'(c.ai);
		br = 128'(c.br);
		bi = 128'(c.bi);
		r = '0;
		ovf = 1'b0;
		case (c.op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (c.op == OP_ADD) begin
					vre = ar + br;
					vim = ai + bi;
				end else if (c.op == OP_SUB) begin
					vre = ar - br;
					vim = ai - bi;
				end else if (c.op == OP_MUL) begin
					vre = round_product(ar * br - ai * bi);
					vim = round_product(ar * bi + ai * br);
				end else begin
					den = br * br + bi * bi;
					if (den == 0) begin
						r.dz = 1'b1;
						return r;
					end
					vre = round_quotient(ar * br + ai * bi, den);
					vim = round_quotient(ai * br - ar * bi, den);
				end
				r.re = clamp_word(vre, ovf);
				r.im = clamp_word(vim, ovf);
				r.ovf = ovf;
			end
			OP_CMP: r.eq = (c.ar == c.br) && (c.ai == c.bi);
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		n_errors++;
	endtask

	// operand mix: extremes, small magnitudes near the binary point, or anything
	function automatic logic signed [DW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sh0;
					3: return 32'sh00010000;
					4: return -32'sh00010000;
					default: return 32'sh00000001;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			4: return $signed($urandom_range(0, 64)) - 32;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic signed [DW-1:0] ar,
			input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
			input logic signed [DW-1:0] bi);
		cmd_t c;
		c.op = op;
		c.ar = ar;
		c.ai = ai;
		c.br = br;
		c.bi = bi;
		return c;
	endfunction

	// append one item to the pending queue
	task automatic enqueue_cmd(input cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// sender idling follows phases of 150 items: none, heavy, none, light
	function automatic bit sender_idles();
		case ((n_sent / 150) % 4)
			1: return $urandom_range(0, 99) < 72;
			3: return $urandom_range(0, 99) < 8;
			default: return 1'b0;
		endcase
	endfunction

	// driver: an item is taken at an edge with start high and busy low
	always @(posedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (start && !busy) begin
				c = make_cmd(operation, a_re, a_im, b_re, b_im);
				expected_results.insert(expected_results.size(), complex_result(c));
				quiet_cycles = 0;
			end
			if (start && busy) begin
				// hold the item until it is taken
			end else if (pending_cmds.size() > 0 && !sender_idles()) begin
				c = pending_cmds.pop_front();
				operation <= c.op;
				a_re <= c.ar;
				a_im <= c.ai;
				b_re <= c.br;
				b_im <= c.bi;
				start <= 1'b1;
				n_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done strobe is checked against the oldest prediction
	always @(posedge clk) begin
		res_t w;
		if (arst_n && done) begin
			quiet_cycles = 0;
			if (expected_results.size() == 0) begin
				$display("mismatch: result with no item outstanding");
				n_errors++;
			end else begin
				w = expected_results.pop_front();
				if (result_re !== w.re) report_mismatch("result_re", result_re, w.re);
				if (result_im !== w.im) report_mismatch("result_im", result_im, w.im);
				if (is_equal !== w.eq)
					report_mismatch("is_equal", DW'(is_equal), DW'(w.eq));
				if (divide_by_zero !== w.dz)
					report_mismatch("divide_by_zero", DW'(divide_by_zero), DW'(w.dz));
				if (overflow !== w.ovf)
					report_mismatch("overflow", DW'(overflow), DW'(w.ovf));
			end
		end
	end

	// watchdog on cycles with nothing taken or delivered
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("complex_arithmetic_unit_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0] op;
		cmd_t c;
		// directed items: extremes, every op, zero divisor, unused codes
		enqueue_cmd(make_cmd(OP_ADD, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000));
		enqueue_cmd(make_cmd(OP_ADD, 32'sh00010000, -32'sh00008000, 32'sh1, 32'sh0));
		enqueue_cmd(make_cmd(OP_SUB, 32'sh80000000, 32'sh7fffffff,
			32'sh1, -32'sh1));
		enqueue_cmd(make_cmd(OP_SUB, 32'sh5, 32'sh5, 32'sh5, 32'sh5));
		enqueue_cmd(make_cmd(OP_MUL, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000));
		enqueue_cmd(make_cmd(OP_MUL, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff));
		enqueue_cmd(make_cmd(OP_MUL, 32'sh00018000, 32'sh0, 32'sh00018000, 32'sh0));
		enqueue_cmd(make_cmd(OP_MUL, 32'sh1, 32'sh0, 32'sh00008000, 32'sh0));
		enqueue_cmd(make_cmd(OP_MUL, -32'sh1, 32'sh0, 32'sh00008000, 32'sh0));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh00010000, 32'sh00010000, 32'sh0, 32'sh0));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh0));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh00010000, 32'sh0, 32'sh00030000, 32'sh0));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh1, -32'sh1, 32'sh7fffffff, 32'sh7fffffff));
		enqueue_cmd(make_cmd(OP_DIV, 32'sh0, 32'sh0, 32'sh0, 32'sh1));
		enqueue_cmd(make_cmd(OP_CMP, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000));
		enqueue_cmd(make_cmd(OP_CMP, 32'sh1, 32'sh2, 32'sh1, 32'sh3));
		enqueue_cmd(make_cmd(OP_CMP, 32'sh1, 32'sh2, 32'sh0, 32'sh2));
		enqueue_cmd(make_cmd(3'd5, 32'sh7fffffff, 32'sh1, 32'sh2, 32'sh3));
		enqueue_cmd(make_cmd(3'd6, 32'sh80000000, 32'sh1, 32'sh2, 32'sh3));
		enqueue_cmd(make_cmd(3'd7, -32'sh1, -32'sh1, -32'sh1, -32'sh1));
		// random items, mostly real operations
		repeat (1130) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			c = make_cmd(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
			if (op == OP_CMP && $urandom_range(0, 1)) begin
				c.br = c.ar;
				c.bi = ($urandom_range(0, 2) == 0) ? c.ai ^ (32'sh1 << $urandom_range(0, 31))
					: c.ai;
			end
			if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
				c.br = '0;
				c.bi = '0;
			end
			enqueue_cmd(c);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cmds.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("complex_arithmetic_unit_tb: PASS");
		else
			$display("complex_arithmetic_unit_tb: FAIL");
		$finish;
	end
endmodule
